// ----- hdl/flsc_pkg.sv -----
// Package with constants, codes and types of the frequency load-shed controller.
package flsc_pkg;

  // Sizes of the load mask and the period count.
  localparam int LOADS      = 8;
  localparam int COUNT_BITS = 16;

  // Configuration register widths and port width.
  localparam int FTH_W  = 10;
  localparam int ROC_W  = 10;
  localparam int HOLD_W = 16;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] CFG_FREQ = 2'd0;
  localparam logic [IDX_W-1:0] CFG_ROC  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_HOLD = 2'd2;

  // Reset values.
  localparam logic [FTH_W-1:0]      FTH_RESET   = FTH_W'(50);
  localparam logic [ROC_W-1:0]      ROC_RESET   = ROC_W'(10);
  localparam logic [HOLD_W-1:0]     HOLD_RESET  = HOLD_W'(500);
  localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(400);

  // Reference frequency numerator and the rate scale 2 * 16000^2.
  localparam int REF_FREQ  = 16000;
  localparam int SCALE_W   = 29;
  localparam logic [SCALE_W-1:0] ROC_SCALE = SCALE_W'(2 * REF_FREQ * REF_FREQ);

  // Widths of the serial products.
  localparam int MPL_W  = COUNT_BITS + 1;
  localparam int CNT_W  = $clog2(MPL_W);
  localparam int FREQ_W = FTH_W + COUNT_BITS;
  localparam int PC_W   = 2 * COUNT_BITS;
  localparam int RHS_W  = 3 * COUNT_BITS + 1;
  localparam int LHS_W  = SCALE_W + COUNT_BITS;
  localparam int ACC_W  = RHS_W + ROC_W;

  // Request types.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DONE
  } state_e;

  // Product being formed by the serial multiplier.
  typedef enum logic [2:0] {
    PH_FREQ,
    PH_PC,
    PH_RHS,
    PH_LHS,
    PH_ROC
  } phase_e;

  // Pair of load masks.
  typedef struct packed {
    logic [LOADS-1:0] conn;
    logic [LOADS-1:0] shed;
  } masks_t;

endpackage

// ----- hdl/frequency_load_shed_controller_unit.sv -----
// Frequency load-shed controller: stability tests and load connect/shed control.
// Every request returns one result. A tick request goes from acceptance straight
// to the done state. In a sample request the frequency and rate-of-change tests
// are exact integer cross-multiplications done by one shift-add multiplier that
// takes one multiplier bit per cycle, over five products in turn. One request is
// worked on at a time; a new request is taken once the previous result has gone
// to the output register. Configuration is written through a plain write port.
module frequency_load_shed_controller_unit
  import flsc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic [15:0]           period_count_i,
  input  logic [7:0]            switches_i,
  input  logic                  load_management_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            loads_connected_o,
  output logic [7:0]            loads_shed_o,
  output logic                  unstable_o,
  output logic                  hold_running_o
);

  // Configuration registers.
  logic [FTH_W-1:0]  fth_q;
  logic [ROC_W-1:0]  roc_q;
  logic [HOLD_W-1:0] hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fth_q  <= FTH_RESET;
      roc_q  <= ROC_RESET;
      hold_q <= HOLD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FREQ: fth_q  <= cfg_data_i[FTH_W-1:0];
        CFG_ROC:  roc_q  <= cfg_data_i[ROC_W-1:0];
        CFG_HOLD: hold_q <= cfg_data_i[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Helper: highest set bit of a mask.
  function automatic logic [LOADS-1:0] top_bit(input logic [LOADS-1:0] v);
    logic [LOADS-1:0] b;
    b = '0;
    for (int i = 0; i < LOADS; i++) begin
      if (v[i]) b = LOADS'(1) << i;
    end
    return b;
  endfunction

  // Connect the highest waiting load.
  function automatic masks_t do_connect(input logic [LOADS-1:0] sw, input masks_t m);
    masks_t r;
    logic [LOADS-1:0] b;
    r = m;
    b = top_bit(sw - m.conn);
    if (sw != '0 && m.conn < sw) begin
      r.conn = m.conn + b;
      if (m.shed >= b) r.shed = m.shed - b;
    end
    return r;
  endfunction

  // Shed the lowest connected load.
  function automatic masks_t do_shed(input logic [LOADS-1:0] sw, input masks_t m);
    masks_t r;
    logic [LOADS-1:0] b;
    r = m;
    b = m.conn & (~m.conn + LOADS'(1));
    if (sw != '0 && m.conn != '0) begin
      r.conn = m.conn - b;
      r.shed = m.shed + b;
    end
    return r;
  endfunction

  // Sequencer and latched request.
  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  type_q;
  logic [COUNT_BITS-1:0] c_q;
  logic [LOADS-1:0]      sw_q;
  logic                  mode_q;

  // Serial multiplier.
  logic [ACC_W-1:0] acc_q, acc_d, mcand_q, mcand_d;
  logic [MPL_W-1:0] mpl_q, mpl_d;
  logic [ACC_W-1:0] step_sum;
  logic [FREQ_W-1:0] freq_q;
  logic [RHS_W-1:0]  rhs_q;
  logic [LHS_W-1:0]  lhs_q;
  logic              mul_last;

  // Controller state.
  logic [COUNT_BITS-1:0] prev_q, prev_d;
  logic                  snew_q, snew_d, sold_q, sold_d;
  logic [LOADS-1:0]      swl_q, swl_d;
  masks_t                m_q, m_d;
  logic [HOLD_W-1:0]     rem_q, rem_d;
  logic                  act_q, act_d, exp_q, exp_d;

  // Output register.
  logic             out_valid_q;
  logic [LOADS-1:0] oconn_q, oshed_q;
  logic             ounst_q, orun_q;

  logic                  accept;
  logic                  commit;
  logic [COUNT_BITS-1:0] c_in;
  logic [COUNT_BITS-1:0] diff;
  logic [MPL_W-1:0]      psum;
  logic                  unst;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign commit     = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign c_in = (period_count_i[COUNT_BITS-1:0] == '0) ? COUNT_BITS'(1)
                                                       : period_count_i[COUNT_BITS-1:0];
  assign diff = (prev_q > c_q) ? (prev_q - c_q) : (c_q - prev_q);
  assign psum = MPL_W'(prev_q) + MPL_W'(c_q);
  assign step_sum = acc_q + (mpl_q[0] ? mcand_q : '0);
  assign mul_last = (cnt_q == CNT_W'(MPL_W - 1));

  // Sequencer: one multiplier bit per cycle, operands of the next product loaded at the end.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    mcand_d = mcand_q;
    mpl_d   = mpl_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_TICK) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_MUL;
            phase_d = PH_FREQ;
            cnt_d   = '0;
            acc_d   = '0;
            mcand_d = ACC_W'(fth_q);
            mpl_d   = MPL_W'(c_in);
          end
        end
      end
      ST_MUL: begin
        acc_d   = step_sum;
        mcand_d = mcand_q << 1;
        mpl_d   = mpl_q >> 1;
        cnt_d   = cnt_q + CNT_W'(1);
        if (mul_last) begin
          cnt_d = '0;
          acc_d = '0;
          unique case (phase_q)
            PH_FREQ: begin
              phase_d = PH_PC;
              mcand_d = ACC_W'(prev_q);
              mpl_d   = MPL_W'(c_q);
            end
            PH_PC: begin
              phase_d = PH_RHS;
              mcand_d = ACC_W'(step_sum[PC_W-1:0]);
              mpl_d   = psum;
            end
            PH_RHS: begin
              phase_d = PH_LHS;
              mcand_d = ACC_W'(ROC_SCALE);
              mpl_d   = MPL_W'(diff);
            end
            PH_LHS: begin
              phase_d = PH_ROC;
              mcand_d = ACC_W'(rhs_q);
              mpl_d   = MPL_W'(roc_q);
            end
            PH_ROC: begin
              acc_d   = step_sum;
              state_d = ST_DONE;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_DONE: begin
        if (commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Stability decision from the finished products.
  always_comb begin
    unst = (FREQ_W'(REF_FREQ) < freq_q);
    if (roc_q == '0) begin
      if (diff != '0) unst = 1'b1;
    end else if (ACC_W'(rhs_q) <= ACC_W'(lhs_q) && ACC_W'(lhs_q) > acc_q) begin
      unst = 1'b1;
    end
  end

  // Controller update for a tick or a sample.
  always_comb begin
    masks_t m;
    m      = m_q;
    prev_d = prev_q;
    snew_d = snew_q;
    sold_d = sold_q;
    swl_d  = swl_q;
    rem_d  = rem_q;
    act_d  = act_q;
    exp_d  = exp_q;
    if (type_q == REQ_TICK) begin
      if (act_q) begin
        if (rem_q <= HOLD_W'(1)) begin
          rem_d = '0;
          act_d = 1'b0;
          exp_d = 1'b1;
        end else begin
          rem_d = rem_q - HOLD_W'(1);
        end
      end
    end else begin
      sold_d = snew_q;
      snew_d = unst;
      prev_d = c_q;
      swl_d  = sw_q;
      if (sw_q < swl_q) begin
        m.conn = m.conn & sw_q;
        m.shed = m.shed & sw_q;
      end
      if (!mode_q) begin
        m.conn = sw_q;
        m.shed = '0;
        snew_d = 1'b0;
        sold_d = 1'b0;
      end else if (!sold_d && !snew_d) begin
        if (exp_q) begin
          m = do_connect(sw_q, m);
          if (m.conn != sw_q) begin
            act_d = 1'b1;
            rem_d = hold_q;
          end
          exp_d = 1'b0;
        end else if (!act_q) begin
          m.conn = sw_q;
          m.shed = '0;
        end
      end else if (sold_d && snew_d) begin
        if (exp_q) begin
          m     = do_shed(sw_q, m);
          act_d = 1'b1;
          rem_d = hold_q;
          exp_d = 1'b0;
        end
      end else if (!sold_d) begin
        if (exp_q) begin
          m = do_connect(sw_q, m);
          if (m.conn == sw_q) m = do_shed(sw_q, m);
        end else if (!act_q) begin
          m = do_shed(sw_q, m);
        end
        act_d = 1'b1;
        rem_d = hold_q;
        exp_d = 1'b0;
      end else begin
        if (exp_q) begin
          m = do_shed(sw_q, m);
        end
        if (exp_q || act_q) begin
          act_d = 1'b1;
          rem_d = hold_q;
          exp_d = 1'b0;
        end
      end
    end
    m_d = m;
  end

  // Sequencer registers: state, product phase and bit counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_FREQ;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  // Payload of the request and the products.
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    mpl_q   <= mpl_d;
    if (accept) begin
      type_q <= req_type_i;
      c_q    <= c_in;
      sw_q   <= switches_i[LOADS-1:0];
      mode_q <= load_management_i;
    end
    if (state_q == ST_MUL && mul_last) begin
      unique case (phase_q)
        PH_FREQ: freq_q <= step_sum[FREQ_W-1:0];
        PH_RHS:  rhs_q  <= step_sum[RHS_W-1:0];
        PH_LHS:  lhs_q  <= step_sum[LHS_W-1:0];
        default: ;
      endcase
    end
  end

  // Controller state, updated when the result goes to the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= COUNT_RESET;
      snew_q <= 1'b0;
      sold_q <= 1'b0;
      swl_q  <= '0;
      m_q    <= '0;
      rem_q  <= '0;
      act_q  <= 1'b0;
      exp_q  <= 1'b0;
    end else if (commit) begin
      prev_q <= prev_d;
      snew_q <= snew_d;
      sold_q <= sold_d;
      swl_q  <= swl_d;
      m_q    <= m_d;
      rem_q  <= rem_d;
      act_q  <= act_d;
      exp_q  <= exp_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      oconn_q <= m_d.conn;
      oshed_q <= m_d.shed;
      ounst_q <= snew_d;
      orun_q  <= act_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign loads_connected_o = 8'(oconn_q);
  assign loads_shed_o      = 8'(oshed_q);
  assign unstable_o        = ounst_q;
  assign hold_running_o    = orun_q;

endmodule

// ----- sim/flsc_checker.sv -----
// Checker that watches the load-shed controller's channels, predicts results and compares them.
`timescale 1ns / 100ps
module flsc_checker
  import flsc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  req_type_i,
  input  logic [15:0]           period_count_i,
  input  logic [7:0]            switches_i,
  input  logic                  load_management_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [7:0]            loads_connected_i,
  input  logic [7:0]            loads_shed_i,
  input  logic                  unstable_i,
  input  logic                  hold_running_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [7:0] conn;
    logic [7:0] shed;
    logic       unst;
    logic       hold;
  } status_t;

  // Predicted controller state and configuration.
  logic [FTH_W-1:0]      freq_lim;
  logic [ROC_W-1:0]      roc_lim;
  logic [HOLD_W-1:0]     hold_len;
  logic [COUNT_BITS-1:0] prev_cnt;
  logic                  stab_new, stab_old, hold_act, hold_exp;
  logic [7:0]            sw_last, conn_m, shed_m;
  logic [HOLD_W-1:0]     hold_left;
  status_t               status_q[$];

  assign pending_o = status_q.size();

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  function automatic logic [7:0] highest_bit(input logic [7:0] v);
    logic [7:0] b;
    b = '0;
    for (int i = 0; i < 8; i++) if (v[i]) b = 8'(1) << i;
    return b;
  endfunction

  function automatic logic sample_unstable(input logic [COUNT_BITS-1:0] p,
                                           input logic [COUNT_BITS-1:0] c);
    logic [63:0] d, lhs, rhs;
    d   = (p > c) ? 64'(p - c) : 64'(c - p);
    lhs = 64'(2 * 16000 * 16000) * d;
    rhs = 64'(p) * 64'(c) * (64'(p) + 64'(c));
    if (64'(16000) < 64'(freq_lim) * 64'(c)) return 1'b1;
    if (roc_lim == 0) return lhs != 0;
    if (rhs > lhs) return 1'b0;
    return lhs > 64'(roc_lim) * rhs;
  endfunction

  task automatic restart_hold();
    hold_act  = 1'b1;
    hold_left = hold_len;
    hold_exp  = 1'b0;
  endtask

  task automatic connect_one(input logic [7:0] sw);
    logic [7:0] b;
    if (sw == 0 || conn_m >= sw) return;
    b = highest_bit(sw - conn_m);
    conn_m = conn_m + b;
    if (shed_m >= b) shed_m = shed_m - b;
  endtask

  task automatic shed_one(input logic [7:0] sw);
    logic [7:0] b;
    if (sw == 0 || conn_m == 0) return;
    b = conn_m & (~conn_m + 8'd1);
    conn_m = conn_m - b;
    shed_m = shed_m + b;
  endtask

  task automatic predict_sample(input logic [15:0] cnt, input logic [7:0] sw,
                                input logic mode);
    logic [COUNT_BITS-1:0] c;
    logic [7:0]            sw_prev;
    c = (cnt == 0) ? COUNT_BITS'(1) : cnt;
    stab_old = stab_new;
    stab_new = sample_unstable(prev_cnt, c);
    prev_cnt = c;
    sw_prev  = sw_last;
    sw_last  = sw;
    if (sw < sw_prev) begin
      conn_m &= sw;
      shed_m &= sw;
    end
    if (!mode) begin
      conn_m = sw;
      shed_m = '0;
      stab_new = 1'b0;
      stab_old = 1'b0;
    end else if (!stab_old && !stab_new) begin
      if (hold_exp) begin
        connect_one(sw);
        if (conn_m != sw) restart_hold();
        hold_exp = 1'b0;
      end else if (!hold_act) begin
        conn_m = sw;
        shed_m = '0;
      end
    end else if (stab_old && stab_new) begin
      if (hold_exp) begin
        shed_one(sw);
        restart_hold();
      end
    end else if (!stab_old) begin
      if (hold_exp) begin
        connect_one(sw);
        if (conn_m == sw) shed_one(sw);
        restart_hold();
      end else if (hold_act) begin
        restart_hold();
      end else begin
        shed_one(sw);
        restart_hold();
      end
    end else if (hold_exp || hold_act) begin
      if (hold_exp) shed_one(sw);
      restart_hold();
    end
  endtask

  // Track configuration, predict each request and compare each result.
  always @(posedge clk_i or negedge rst_ni) begin
    status_t want;
    if (!rst_ni) begin
      freq_lim = FTH_RESET;
      roc_lim = ROC_RESET;
      hold_len = HOLD_RESET;
      prev_cnt = COUNT_RESET;
      {stab_new, stab_old, hold_act, hold_exp} = '0;
      {sw_last, conn_m, shed_m} = '0;
      hold_left = '0;
      status_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FREQ: freq_lim = cfg_data_i[FTH_W-1:0];
          CFG_ROC:  roc_lim  = cfg_data_i[ROC_W-1:0];
          CFG_HOLD: hold_len = cfg_data_i[HOLD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (req_type_i == REQ_TICK) begin
          if (hold_act) begin
            if (hold_left <= 1) begin
              hold_left = '0;
              hold_act  = 1'b0;
              hold_exp  = 1'b1;
            end else begin
              hold_left--;
            end
          end
        end else begin
          predict_sample(period_count_i, switches_i, load_management_i);
        end
        status_q.push_back('{conn_m, shed_m, stab_new, hold_act});
      end
      if (out_valid_i && !out_stall_i) begin
        if (status_q.size() == 0) begin
          report_mismatch("unexpected result", 8'h0, 8'h0);
        end else begin
          want = status_q.pop_front();
          if (loads_connected_i !== want.conn)
            report_mismatch("loads_connected", loads_connected_i, want.conn);
          if (loads_shed_i !== want.shed)
            report_mismatch("loads_shed", loads_shed_i, want.shed);
          if (unstable_i !== want.unst)
            report_mismatch("unstable", 8'(unstable_i), 8'(want.unst));
          if (hold_running_i !== want.hold)
            report_mismatch("hold_running", 8'(hold_running_i), 8'(want.hold));
        end
      end
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Top of the load-shed controller testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
  import flsc_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             req_type = 1'b0;
  logic [15:0]      period_count = '0;
  logic [7:0]       switches = '0;
  logic             load_mgmt = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       loads_conn, loads_shed;
  logic             unstable, hold_running;
  int               fail_count, pending;
  bit               long_hold = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  frequency_load_shed_controller_unit uut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .period_count_i(period_count), .switches_i(switches),
    .load_management_i(load_mgmt), .out_valid_o(out_valid),
    .out_stall_i(out_stall), .loads_connected_o(loads_conn),
    .loads_shed_o(loads_shed), .unstable_o(unstable), .hold_running_o(hold_running)
  );

  flsc_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .req_type_i(req_type), .period_count_i(period_count), .switches_i(switches),
    .load_management_i(load_mgmt), .out_valid_i(out_valid),
    .out_stall_i(out_stall), .loads_connected_i(loads_conn),
    .loads_shed_i(loads_shed), .unstable_i(unstable), .hold_running_i(hold_running),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 60);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // Receiver stall: random short and long, plus one long hold-off on request.
  always @(posedge clk) begin
    if (long_hold) out_stall <= 1'b1;
    else if ($urandom_range(0, 3) == 0) out_stall <= ($urandom_range(0, 20) == 0) ?
      1'b1 : ~out_stall;
    else out_stall <= 1'b0;
  end

  // One register write, after which the write port is left idle before the task returns.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one request and hold it until accepted, with an optional gap first.
  // Valid stays high after acceptance so that a following request can go back to back.
  task automatic send_request(input logic rt, input logic [15:0] cnt,
                              input logic [7:0] sw, input logic mode, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    period_count <= cnt;
    switches <= sw;
    load_mgmt <= mode;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic tick_run(input int n);
    for (int i = 0; i < n; i++) send_request(REQ_TICK, 16'($urandom), 8'($urandom), 1'b1, 0);
  endtask

  // Random phase: mostly plausible counts near 400, with switch changes and ticks.
  task automatic random_phase(input int n);
    logic [15:0] cnt;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_request(REQ_TICK, 16'($urandom), 8'($urandom), 1'($urandom),
                                 gap_len());
        4: send_request(REQ_SAMPLE, 16'($urandom), 8'($urandom), 1'($urandom), gap_len());
        default: begin
          cnt = 16'($urandom_range(280, 480));
          send_request(REQ_SAMPLE, cnt, ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                       switches, ($urandom_range(0, 7) != 0), gap_len());
        end
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests: extremes, zero count, both modes, a timer expiry.
    send_request(REQ_SAMPLE, 16'd0, 8'hFF, 1'b1, 0);
    send_request(REQ_SAMPLE, 16'hFFFF, 8'hFF, 1'b1, 0);
    send_request(REQ_SAMPLE, 16'd400, 8'hFF, 1'b0, 0);
    send_request(REQ_SAMPLE, 16'd400, 8'h00, 1'b1, 1);
    send_request(REQ_TICK, 16'd0, 8'h00, 1'b0, 0);
    drain();
    write_reg(CFG_HOLD, 2);
    write_reg(CFG_ROC, 0);
    send_request(REQ_SAMPLE, 16'd320, 8'hA5, 1'b1, 0);
    send_request(REQ_SAMPLE, 16'd321, 8'hA5, 1'b1, 0);
    tick_run(3);
    send_request(REQ_SAMPLE, 16'd321, 8'h5A, 1'b1, 0);
    tick_run(3);
    send_request(REQ_SAMPLE, 16'd322, 8'hF0, 1'b1, 0);
    send_request(REQ_SAMPLE, 16'd322, 8'h0F, 1'b1, 0);
    tick_run(3);
    send_request(REQ_SAMPLE, 16'd322, 8'hFF, 1'b1, 0);
    tick_run(2);
    send_request(REQ_SAMPLE, 16'd322, 8'hFF, 1'b1, 0);
    drain();

    // Long receiver hold-off while requests keep coming.
    write_reg(CFG_FREQ, 0);
    write_reg(CFG_ROC, 999);
    write_reg(CFG_HOLD, 0);
    fork
      begin
        long_hold = 1'b1;
        repeat (600) @(posedge clk);
        long_hold = 1'b0;
      end
      random_phase(20);
    join
    drain();

    // Random phases over several settings.
    write_reg(CFG_FREQ, 50); write_reg(CFG_ROC, 10); write_reg(CFG_HOLD, 3);
    random_phase(300);
    drain();
    write_reg(CFG_FREQ, 999); write_reg(CFG_ROC, 1); write_reg(CFG_HOLD, 1);
    random_phase(150);
    drain();
    write_reg(CFG_FREQ, 45); write_reg(CFG_ROC, 5); write_reg(CFG_HOLD, 65535);
    random_phase(80);
    drain();
    write_reg(CFG_FREQ, 40); write_reg(CFG_ROC, 20); write_reg(CFG_HOLD, 4);
    random_phase(380);
    drain();

    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
